// File: rtl/peer_replay_counter_table_macros.svh
// ----------------------------------------------------------------------------
// Replay table assertion macros
// Shared property wrappers for the checker of the replay counter table.
// ----------------------------------------------------------------------------
`ifndef PEER_REPLAY_COUNTER_TABLE_MACROS_SVH
`define PEER_REPLAY_COUNTER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("replay table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("replay table check failed");

`endif

// File: rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// Replay table package
// Sizes, verdict codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int MAX_SENDERS = 16;
    localparam int IDX_W       = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
    localparam int CNT_W       = $clog2(MAX_SENDERS + 1);
    localparam int MAC_W       = 48;
    localparam int ID_W        = 32;

    localparam logic [1:0] VERDICT_KNOWN   = 2'd0;
    localparam logic [1:0] VERDICT_NEW     = 2'd1;
    localparam logic [1:0] VERDICT_REPLAY  = 2'd2;
    localparam logic [1:0] VERDICT_CLEARED = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the input word, restart the scan
        logic scan;   // read one table entry per cycle
        logic upd;    // resolve a hit: update the id or reject
        logic ins;    // record a new sender at the replace pointer
        logic clr;    // empty the table
        logic emit;   // move the pending result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;    // offered word is a clear request
        logic count_zero;  // table holds no sender
        logic hit;         // entry under compare matches the sender
        logic miss;        // last stored entry compared without a match
        logic out_free;    // output register can take a result
    } t_dp_stat;

endpackage

// File: rtl/prt_datapath.sv
// ----------------------------------------------------------------------------
// Replay table datapath
// Sender table memory, valid bits, replace pointer, scan pipeline and the
// output register.
// ----------------------------------------------------------------------------
module prt_datapath import prt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic             i_kind,
    input  logic [MAC_W-1:0] i_sender_mac,
    input  logic [ID_W-1:0]  i_message_id,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_accepted,
    output logic [1:0]       o_verdict
);

    logic [MAC_W-1:0]       r_mem_mac [MAX_SENDERS];
    logic [ID_W-1:0]        r_mem_id  [MAX_SENDERS];
    logic [MAX_SENDERS-1:0] r_valid;
    logic [IDX_W-1:0]       r_ptr;
    logic [CNT_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_scan_idx;
    logic                   r_scan_done;
    logic                   r_rd_live;
    logic                   r_rd_last;
    logic                   r_rd_vld;
    logic [MAC_W-1:0]       r_rd_mac;
    logic [ID_W-1:0]        r_rd_id;
    logic [IDX_W-1:0]       r_rd_slot;
    logic [MAC_W-1:0]       r_mac;
    logic [ID_W-1:0]        r_id;
    logic                   r_res_acc;
    logic [1:0]             r_res_verdict;
    logic                   r_out_valid;
    logic                   r_out_acc;
    logic [1:0]             r_out_verdict;

    logic hit;
    logic fire;
    logic issue_last;
    logic greater;

    assign hit        = r_rd_live & r_rd_vld & (r_rd_mac == r_mac);
    assign fire       = i_cmd.scan & ~r_scan_done & ~hit;
    assign issue_last = ((CNT_W'(r_scan_idx) + CNT_W'(1)) == r_count);
    assign greater    = (r_id > r_rd_id);

    assign o_stat.is_clear   = i_kind;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.hit        = hit;
    assign o_stat.miss       = r_rd_live & r_rd_last & ~hit;
    assign o_stat.out_free   = ~r_out_valid | i_ready;

    assign o_valid    = r_out_valid;
    assign o_accepted = r_out_acc;
    assign o_verdict  = r_out_verdict;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ptr       <= '0;
            r_count     <= '0;
            r_scan_idx  <= '0;
            r_scan_done <= 1'b0;
            r_rd_live   <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_live <= fire;
            if (i_cmd.load) begin
                r_scan_idx  <= '0;
                r_scan_done <= 1'b0;
            end else if (fire) begin
                r_scan_idx  <= r_scan_idx + IDX_W'(1);
                r_scan_done <= issue_last;
            end
            if (fire) begin
                r_rd_last <= issue_last;
            end
            if (i_cmd.clr) begin
                r_valid <= '0;
                r_ptr   <= '0;
                r_count <= '0;
            end else if (i_cmd.ins) begin
                r_valid[r_ptr] <= 1'b1;
                if (r_ptr == IDX_W'(MAX_SENDERS - 1)) begin
                    r_ptr <= '0;
                end else begin
                    r_ptr <= r_ptr + IDX_W'(1);
                end
                if (r_count != CNT_W'(MAX_SENDERS)) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Table memory, scan read stage and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mac <= i_sender_mac;
            r_id  <= i_message_id;
        end
        if (fire) begin
            r_rd_mac  <= r_mem_mac[r_scan_idx];
            r_rd_id   <= r_mem_id[r_scan_idx];
            r_rd_vld  <= r_valid[r_scan_idx];
            r_rd_slot <= r_scan_idx;
        end
        if (i_cmd.ins) begin
            r_mem_mac[r_ptr] <= r_mac;
            r_mem_id[r_ptr]  <= r_id;
            r_res_acc        <= 1'b1;
            r_res_verdict    <= VERDICT_NEW;
        end else if (i_cmd.upd) begin
            if (greater) begin
                r_mem_id[r_rd_slot] <= r_id;
                r_res_acc           <= 1'b1;
                r_res_verdict       <= VERDICT_KNOWN;
            end else begin
                r_res_acc     <= 1'b0;
                r_res_verdict <= VERDICT_REPLAY;
            end
        end else if (i_cmd.clr) begin
            r_res_acc     <= 1'b0;
            r_res_verdict <= VERDICT_CLEARED;
        end
        if (i_cmd.emit) begin
            r_out_acc     <= r_res_acc;
            r_out_verdict <= r_res_verdict;
        end
    end

endmodule

// File: rtl/prt_controller.sv
// ----------------------------------------------------------------------------
// Replay table controller
// Sequences accept, table scan, update or insert, clear and result hand-off.
// ----------------------------------------------------------------------------
module prt_controller import prt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_CLEAR  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.is_clear) begin
                        n_state = S_CLEAR;
                    end else if (i_stat.count_zero) begin
                        n_state = S_INSERT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_UPDATE;
                end else if (i_stat.miss) begin
                    n_state = S_INSERT;
                end
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DONE;
            end
            S_INSERT: begin
                o_cmd.ins = 1'b1;
                n_state   = S_DONE;
            end
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output register frees up.
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/peer_replay_counter_table.sv
// Timing: a clear or a check into an empty table goes through its clear or insert state
// and then the done state; a check first scans the stored senders one per cycle. The
// single table read port sets this pace. The done state waits for the output register.
// One word is handled at a time; the next word is taken while a result waits.
// Reset: synchronous, active low; the table empties, pointer and count clear, output drops.
// ----------------------------------------------------------------------------
// Peer replay counter table
// Per-sender replay filter. Each known sender keeps its last accepted message
// id; a check passes only with a strictly greater id. New senders are
// recorded first in, first out once the table is full.
// ----------------------------------------------------------------------------
module peer_replay_counter_table import prt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_kind,
    input  logic [MAC_W-1:0] i_sender_mac,
    input  logic [ID_W-1:0]  i_message_id,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_accepted,
    output logic [1:0]       o_verdict
);

    // Commands go one way, status the other; nothing else crosses.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Controller: accepts a word in idle, walks scan -> update/insert, straight to insert
    // for an empty table, or clear, then waits for the output register before returning to idle.
    prt_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath: the sender table lives here. Occupied slots are always
    // 0..count-1 until the table fills, so the scan stops at the count and
    // an empty table skips it. The replace pointer marks the oldest entry
    // once the table is full.
    prt_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_kind       (i_kind),
        .i_sender_mac (i_sender_mac),
        .i_message_id (i_message_id),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_accepted   (o_accepted),
        .o_verdict    (o_verdict)
    );

endmodule

// File: rtl/prt_checker.sv
// ----------------------------------------------------------------------------
// Replay table checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "peer_replay_counter_table_macros.svh"

module prt_checker import prt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             i_kind,
    input logic [MAC_W-1:0] i_sender_mac,
    input logic [ID_W-1:0]  i_message_id,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_accepted,
    input logic [1:0]       o_verdict
);

    logic in_fire;
    logic out_stall;

    assign in_fire   = i_valid & o_ready;
    assign out_stall = o_valid & ~i_ready;

    // One word at a time: after an accept the block is busy.
    `PRT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !o_ready)

    // Idle with an empty output register: no result can appear next cycle.
    `PRT_ASSERT_NEXT(a_no_spurious_result, i_clk, i_rst_n, o_ready && !o_valid, !o_valid)

    // Stalled result holds.
    `PRT_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, out_stall,
        o_valid && $stable(o_accepted) && $stable(o_verdict))

    // Accepted flag agrees with the verdict.
    `PRT_ASSERT_NOW(a_flag_matches_verdict, i_clk, i_rst_n, o_valid,
        o_accepted == ((o_verdict == VERDICT_KNOWN) || (o_verdict == VERDICT_NEW)))

endmodule

bind peer_replay_counter_table prt_checker u_prt_checker (.*);
